>>> hdl/bvu_pkg.sv
// Boid velocity update: shared types, register codes and reset values.
// Used by every module of the block; no dependencies.
package bvu_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_RADIUS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COH_GAIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_SIZE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LO     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_HI     = 3'd7;

  typedef struct packed {
    logic [30:0] align_radius;
    logic [30:0] sep_radius;
    logic [15:0] align_gain;
    logic [15:0] sep_gain;
    logic [15:0] coh_gain;
    logic [30:0] margin_size;
    logic [30:0] speed_lo;
    logic [30:0] speed_hi;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    align_radius: 31'd6553600,
    sep_radius:   31'd1310720,
    align_gain:   16'd3277,
    sep_gain:     16'd3277,
    coh_gain:     16'd33,
    margin_size:  31'd6553600,
    speed_lo:     31'd196608,
    speed_hi:     31'd393216
  };

  // classified neighbor item, front to back
  typedef struct packed {
    logic signed [31:0] self_px;
    logic signed [31:0] self_py;
    logic signed [31:0] self_vx;
    logic signed [31:0] self_vy;
    logic signed [31:0] nb_px;
    logic signed [31:0] nb_py;
    logic signed [31:0] nb_vx;
    logic signed [31:0] nb_vy;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               in_align;
    logic               in_sep;
    logic               first;
    logic               last;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BS_ACC,
    BS_DIV_GO,
    BS_DIV_WAIT,
    BS_GMUL,
    BS_GADD,
    BS_HALVE,
    BS_N0,
    BS_N1,
    BS_N2,
    BS_N3,
    BS_SQRT,
    BS_RMUL,
    BS_RDIV_GO,
    BS_RDIV_WAIT,
    BS_OUT
  } bst_t;

endpackage

>>> hdl/bvu_div.sv
// Boid velocity update: iterative unsigned divider, one quotient bit per cycle.
// 64-bit dividend, 32-bit divisor. Depends on bvu_pkg.
module bvu_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bvu_pkg::div_req_t req,
  output bvu_pkg::div_rsp_t rsp
);

  localparam logic [6:0] LAST_STEP = 7'd63;

  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] rem_r;
  logic [63:0] q_r;
  logic [31:0] d_r;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_r, q_r[63]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= req.dividend;
        d_r    <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? 32'(trial - {1'b0, d_r}) : trial[31:0];
        q_r   <= {q_r[62:0], fits};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

>>> hdl/bvu_fifo.sv
// Boid velocity update: short item queue between front and back.
// Flop-based, one read port. Depends on bvu_pkg.
module bvu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bvu_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output bvu_pkg::item_t dout,
  output logic           valid
);

  localparam int AW = $clog2(DEPTH);

  bvu_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [AW:0]    cnt_r;

  assign full  = cnt_r == (AW+1)'(DEPTH);
  assign valid = cnt_r != '0;
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

>>> hdl/bvu_front.sv
// Boid velocity update: input stage. Takes neighbor items, forms offsets and
// runs the two radius tests over a three-stage pipeline. Depends on bvu_pkg.
module bvu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  bvu_pkg::cfg_t  cfg,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [255:0]   in_tdata,
  input  logic           in_tuser,
  input  logic           in_tlast,
  output logic           q_push,
  output bvu_pkg::item_t q_item,
  input  logic           q_full
);

  logic               adv;
  logic               s1_v_r;
  logic [255:0]       s1_d_r;
  logic               s1_first_r;
  logic               s1_last_r;
  bvu_pkg::item_t     s1_it;
  logic [31:0]        ax;
  logic [31:0]        ay;

  logic               s2_v_r;
  bvu_pkg::item_t     s2_it_r;
  logic [31:0]        s2_ax_r;
  logic [31:0]        s2_ay_r;
  logic               s2_fa_r;
  logic               s2_fs_r;

  logic               s3_v_r;
  bvu_pkg::item_t     s3_it_r;
  logic [61:0]        s3_sqx_r;
  logic [61:0]        s3_sqy_r;
  logic               s3_fa_r;
  logic               s3_fs_r;

  logic [61:0]        ra2_r;
  logic [61:0]        rs2_r;
  logic [62:0]        d2;

  assign adv       = !s3_v_r || !q_full;
  assign in_tready = adv;

  always_comb begin
    s1_it          = '0;
    s1_it.self_px  = $signed(s1_d_r[31:0]);
    s1_it.self_py  = $signed(s1_d_r[63:32]);
    s1_it.self_vx  = $signed(s1_d_r[95:64]);
    s1_it.self_vy  = $signed(s1_d_r[127:96]);
    s1_it.nb_px    = $signed(s1_d_r[159:128]);
    s1_it.nb_py    = $signed(s1_d_r[191:160]);
    s1_it.nb_vx    = $signed(s1_d_r[223:192]);
    s1_it.nb_vy    = $signed(s1_d_r[255:224]);
    s1_it.dx       = 33'(s1_it.nb_px) - 33'(s1_it.self_px);
    s1_it.dy       = 33'(s1_it.nb_py) - 33'(s1_it.self_py);
    s1_it.first    = s1_first_r;
    s1_it.last     = s1_last_r;
    ax = s1_it.dx[32] ? 32'(-s1_it.dx) : s1_it.dx[31:0];
    ay = s1_it.dy[32] ? 32'(-s1_it.dy) : s1_it.dy[31:0];
  end

  always_ff @(posedge clk) begin
    ra2_r <= 62'(cfg.align_radius) * 62'(cfg.align_radius);
    rs2_r <= 62'(cfg.sep_radius) * 62'(cfg.sep_radius);
    if (adv) begin
      s1_d_r     <= in_tdata;
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
      s2_it_r    <= s1_it;
      s2_ax_r    <= ax;
      s2_ay_r    <= ay;
      s2_fa_r    <= (ax >= {1'b0, cfg.align_radius}) || (ay >= {1'b0, cfg.align_radius});
      s2_fs_r    <= (ax >= {1'b0, cfg.sep_radius}) || (ay >= {1'b0, cfg.sep_radius});
      s3_it_r    <= s2_it_r;
      s3_sqx_r   <= 62'(s2_ax_r[30:0]) * 62'(s2_ax_r[30:0]);
      s3_sqy_r   <= 62'(s2_ay_r[30:0]) * 62'(s2_ay_r[30:0]);
      s3_fa_r    <= s2_fa_r;
      s3_fs_r    <= s2_fs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  assign d2 = 63'(s3_sqx_r) + 63'(s3_sqy_r);

  always_comb begin
    q_item          = s3_it_r;
    q_item.in_align = !s3_fa_r && (d2 < 63'(ra2_r));
    q_item.in_sep   = !s3_fs_r && (d2 < 63'(rs2_r));
  end

  assign q_push = s3_v_r && !q_full;

endmodule

>>> hdl/bvu_back.sv
// Boid velocity update: accumulation and final velocity sequencer.
// Uses the shared divider for averages and rescaling. Depends on bvu_pkg.
module bvu_back #(
  parameter int WINDOW_X       = 1024,
  parameter int WINDOW_Y       = 768,
  parameter int TURN_STEP_Q16  = 13107,
  parameter int MAX_NEIGHBOURS = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bvu_pkg::cfg_t     cfg,
  input  bvu_pkg::item_t    q_item,
  input  logic              q_valid,
  output logic              q_pop,
  output bvu_pkg::div_req_t div_req,
  input  bvu_pkg::div_rsp_t div_rsp,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata
);

  localparam longint WXQ = longint'(WINDOW_X) * 65536;
  localparam longint WYQ = longint'(WINDOW_Y) * 65536;
  localparam logic [2:0] JOB_PUSH_LAST = 3'd1;
  localparam logic [2:0] JOB_LAST      = 3'd5;

  bvu_pkg::bst_t st_r, st_nxt;

  logic signed [47:0] sum_px_r, sum_py_r, sum_vx_r, sum_vy_r, push_x_r, push_y_r;
  logic signed [47:0] sum_px_nxt, sum_py_nxt, sum_vx_nxt, sum_vy_nxt;
  logic signed [47:0] push_x_nxt, push_y_nxt;
  logic [15:0]        cnt_r, cnt_nxt, cnt_base;
  logic               take;

  logic signed [31:0] spx_r, spy_r, svx_r, svy_r;
  logic signed [31:0] avg_r [4];
  logic [1:0]         k_r;
  logic [2:0]         j_r;
  logic signed [64:0] prod_r;
  logic signed [51:0] ox_r, oy_r;
  logic               big_r, phase_r, rk_r;
  logic [63:0]        sq_r, n2_r, sn_r, sres_r;
  logic [4:0]         it_r;
  logic               out_v_r;
  logic [63:0]        out_d_r;

  logic signed [47:0] g_a;
  logic [15:0]        g_g;
  logic [31:0]        mul_a, mul_b;
  logic               mul_en;
  logic signed [47:0] dsum;
  logic signed [51:0] wall_x, wall_y;
  logic signed [33:0] px34, py34, m34;
  logic               fits, resc, load;
  logic [31:0]        mag_x, mag_y, avg_q;
  logic [63:0]        sq_bit, sq_try;
  logic [30:0]        target;
  logic signed [32:0] rs_val;
  logic [32:0]        rs_mag;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    return v[47:0];
  endfunction

  // accumulation
  always_comb begin
    sum_px_nxt = q_item.first ? '0 : sum_px_r;
    sum_py_nxt = q_item.first ? '0 : sum_py_r;
    sum_vx_nxt = q_item.first ? '0 : sum_vx_r;
    sum_vy_nxt = q_item.first ? '0 : sum_vy_r;
    push_x_nxt = q_item.first ? '0 : push_x_r;
    push_y_nxt = q_item.first ? '0 : push_y_r;
    cnt_base   = q_item.first ? '0 : cnt_r;
    take       = q_item.in_align && (cnt_base < 16'(MAX_NEIGHBOURS));
    cnt_nxt    = cnt_base;
    if (take) begin
      sum_px_nxt = sum_px_nxt + 48'(q_item.nb_px);
      sum_py_nxt = sum_py_nxt + 48'(q_item.nb_py);
      sum_vx_nxt = sum_vx_nxt + 48'(q_item.nb_vx);
      sum_vy_nxt = sum_vy_nxt + 48'(q_item.nb_vy);
      cnt_nxt    = cnt_base + 16'd1;
    end
    if (q_item.in_sep) begin
      push_x_nxt = sat48(49'(push_x_nxt) - 49'(q_item.dx));
      push_y_nxt = sat48(49'(push_y_nxt) - 49'(q_item.dy));
    end
  end

  // wall turn steps
  always_comb begin
    px34   = 34'(q_item.self_px);
    py34   = 34'(q_item.self_py);
    m34    = $signed({3'b0, cfg.margin_size});
    wall_x = '0;
    wall_y = '0;
    if (px34 < m34)              wall_x = wall_x + 52'(TURN_STEP_Q16);
    if (px34 > 34'(WXQ) - m34)   wall_x = wall_x - 52'(TURN_STEP_Q16);
    if (py34 < m34)              wall_y = wall_y + 52'(TURN_STEP_Q16);
    if (py34 > 34'(WYQ) - m34)   wall_y = wall_y - 52'(TURN_STEP_Q16);
  end

  // final datapath helpers
  always_comb begin
    fits   = (ox_r[51:31] == '0 || ox_r[51:31] == '1) &&
             (oy_r[51:31] == '0 || oy_r[51:31] == '1);
    mag_x  = ox_r[31] ? 32'(-ox_r[31:0]) : ox_r[31:0];
    mag_y  = oy_r[31] ? 32'(-oy_r[31:0]) : oy_r[31:0];
    target = phase_r ? cfg.speed_lo : cfg.speed_hi;
    resc   = (n2_r != '0) && (phase_r ? (n2_r < sq_r) : (big_r || n2_r > sq_r));
    sq_bit = 64'h4000_0000_0000_0000 >> {it_r, 1'b0};
    sq_try = sres_r + sq_bit;
    load   = !out_v_r || out_tready;
    avg_q  = div_rsp.quot[31:0];
    rs_mag = {1'b0, div_rsp.quot[31:0]};
    rs_val = (rk_r ? oy_r[51] : ox_r[51]) ? -$signed(rs_mag) : $signed(rs_mag);
    unique case (k_r)
      2'd0:    dsum = sum_vx_r;
      2'd1:    dsum = sum_vy_r;
      2'd2:    dsum = sum_px_r;
      default: dsum = sum_py_r;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bvu_pkg::BS_ACC:
        if (q_valid && q_item.last)
          st_nxt = (cnt_nxt != '0) ? bvu_pkg::BS_DIV_GO : bvu_pkg::BS_GMUL;
      bvu_pkg::BS_DIV_GO:   st_nxt = bvu_pkg::BS_DIV_WAIT;
      bvu_pkg::BS_DIV_WAIT:
        if (div_rsp.done) st_nxt = (k_r == 2'd3) ? bvu_pkg::BS_GMUL : bvu_pkg::BS_DIV_GO;
      bvu_pkg::BS_GMUL:     st_nxt = bvu_pkg::BS_GADD;
      bvu_pkg::BS_GADD:
        if ((j_r == JOB_PUSH_LAST && cnt_r == '0) || j_r == JOB_LAST)
          st_nxt = bvu_pkg::BS_HALVE;
        else
          st_nxt = bvu_pkg::BS_GMUL;
      bvu_pkg::BS_HALVE:    if (fits) st_nxt = bvu_pkg::BS_N0;
      bvu_pkg::BS_N0:       st_nxt = bvu_pkg::BS_N1;
      bvu_pkg::BS_N1:       st_nxt = bvu_pkg::BS_N2;
      bvu_pkg::BS_N2:       st_nxt = bvu_pkg::BS_N3;
      bvu_pkg::BS_N3:
        if (resc)         st_nxt = bvu_pkg::BS_SQRT;
        else if (phase_r) st_nxt = bvu_pkg::BS_OUT;
        else              st_nxt = bvu_pkg::BS_N0;
      bvu_pkg::BS_SQRT:     if (it_r == 5'd31) st_nxt = bvu_pkg::BS_RMUL;
      bvu_pkg::BS_RMUL:     st_nxt = bvu_pkg::BS_RDIV_GO;
      bvu_pkg::BS_RDIV_GO:  st_nxt = bvu_pkg::BS_RDIV_WAIT;
      bvu_pkg::BS_RDIV_WAIT:
        if (div_rsp.done) begin
          if (!rk_r)        st_nxt = bvu_pkg::BS_RMUL;
          else if (phase_r) st_nxt = bvu_pkg::BS_OUT;
          else              st_nxt = bvu_pkg::BS_N0;
        end
      bvu_pkg::BS_OUT:      if (load) st_nxt = bvu_pkg::BS_ACC;
      default:              st_nxt = bvu_pkg::BS_ACC;
    endcase
  end

  // outputs
  always_comb begin
    q_pop   = 1'b0;
    div_req = '0;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    g_a     = push_x_r;
    g_g     = cfg.sep_gain;
    unique case (j_r)
      3'd0: g_a = push_x_r;
      3'd1: g_a = push_y_r;
      3'd2: g_a = 48'(33'(avg_r[0]) - 33'(svx_r));
      3'd3: g_a = 48'(33'(avg_r[1]) - 33'(svy_r));
      3'd4: g_a = 48'(33'(avg_r[2]) - 33'(spx_r));
      default: g_a = 48'(33'(avg_r[3]) - 33'(spy_r));
    endcase
    if (j_r == 3'd2 || j_r == 3'd3) g_g = cfg.align_gain;
    if (j_r == 3'd4 || j_r == JOB_LAST) g_g = cfg.coh_gain;
    unique case (st_r)
      bvu_pkg::BS_ACC:    q_pop = q_valid;
      bvu_pkg::BS_DIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(dsum[47] ? 48'(-dsum) : dsum);
        div_req.divisor  = 32'(cnt_r);
      end
      bvu_pkg::BS_N0: begin
        mul_en = 1'b1; mul_a = mag_x; mul_b = mag_x;
      end
      bvu_pkg::BS_N1: begin
        mul_en = 1'b1; mul_a = mag_y; mul_b = mag_y;
      end
      bvu_pkg::BS_N2: begin
        mul_en = 1'b1; mul_a = {1'b0, target}; mul_b = {1'b0, target};
      end
      bvu_pkg::BS_RMUL: begin
        mul_en = 1'b1; mul_a = rk_r ? mag_y : mag_x; mul_b = {1'b0, target};
      end
      bvu_pkg::BS_RDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = sq_r;
        div_req.divisor  = sres_r[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= bvu_pkg::BS_ACC;
      out_v_r  <= 1'b0;
      sum_px_r <= '0;
      sum_py_r <= '0;
      sum_vx_r <= '0;
      sum_vy_r <= '0;
      push_x_r <= '0;
      push_y_r <= '0;
      cnt_r    <= '0;
    end else begin
      st_r <= st_nxt;
      out_v_r <= (st_r == bvu_pkg::BS_OUT && load) || (out_v_r && !out_tready);
      if (mul_en) sq_r <= 64'(mul_a) * 64'(mul_b);
      unique case (st_r)
        bvu_pkg::BS_ACC:
          if (q_valid) begin
            sum_px_r <= sum_px_nxt;
            sum_py_r <= sum_py_nxt;
            sum_vx_r <= sum_vx_nxt;
            sum_vy_r <= sum_vy_nxt;
            push_x_r <= push_x_nxt;
            push_y_r <= push_y_nxt;
            cnt_r    <= cnt_nxt;
            if (q_item.last) begin
              spx_r   <= q_item.self_px;
              spy_r   <= q_item.self_py;
              svx_r   <= q_item.self_vx;
              svy_r   <= q_item.self_vy;
              ox_r    <= 52'(q_item.self_vx) + wall_x;
              oy_r    <= 52'(q_item.self_vy) + wall_y;
              big_r   <= 1'b0;
              phase_r <= 1'b0;
              k_r     <= '0;
              j_r     <= '0;
            end
          end
        bvu_pkg::BS_DIV_WAIT:
          if (div_rsp.done) begin
            avg_r[k_r] <= dsum[47] ? -$signed(avg_q) : $signed(avg_q);
            k_r        <= k_r + 2'd1;
          end
        bvu_pkg::BS_GMUL: prod_r <= 65'(g_a) * 65'($signed({1'b0, g_g}));
        bvu_pkg::BS_GADD: begin
          if (j_r[0]) oy_r <= oy_r + 52'(prod_r >>> 16);
          else        ox_r <= ox_r + 52'(prod_r >>> 16);
          j_r <= j_r + 3'd1;
        end
        bvu_pkg::BS_HALVE:
          if (!fits) begin
            ox_r  <= ox_r >>> 1;
            oy_r  <= oy_r >>> 1;
            big_r <= 1'b1;
          end
        bvu_pkg::BS_N1: n2_r <= sq_r;
        bvu_pkg::BS_N2: n2_r <= n2_r + sq_r;
        bvu_pkg::BS_N3:
          if (resc) begin
            sn_r   <= n2_r;
            sres_r <= '0;
            it_r   <= '0;
            rk_r   <= 1'b0;
          end else begin
            phase_r <= 1'b1;
          end
        bvu_pkg::BS_SQRT: begin
          if (sn_r >= sq_try) begin
            sn_r   <= sn_r - sq_try;
            sres_r <= (sres_r >> 1) + sq_bit;
          end else begin
            sres_r <= sres_r >> 1;
          end
          it_r <= it_r + 5'd1;
        end
        bvu_pkg::BS_RDIV_WAIT:
          if (div_rsp.done) begin
            if (rk_r) oy_r <= 52'(rs_val);
            else      ox_r <= 52'(rs_val);
            rk_r <= ~rk_r;
            if (rk_r) phase_r <= 1'b1;
          end
        bvu_pkg::BS_OUT:
          if (load) begin
            out_d_r  <= {oy_r[31:0], ox_r[31:0]};
            sum_px_r <= '0;
            sum_py_r <= '0;
            sum_vx_r <= '0;
            sum_vy_r <= '0;
            push_x_r <= '0;
            push_y_r <= '0;
            cnt_r    <= '0;
          end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

>>> hdl/boid_velocity_update_core.sv
// Boid velocity update, top level: config registers, front, queue, back, divider.
// Depends on bvu_pkg, bvu_front, bvu_fifo, bvu_back, bvu_div.
//
//   channel  dir  handshake          payload
//   in_*     in   tvalid/tready      tdata neighbor item, tuser first, tlast last
//   out_*    out  tvalid/tready      tdata new velocity
//   cfg_*    in   we (no wait)       idx register, wdata value
//
// Neighbor items flow one per cycle, unless the queue is full, through a 3-stage
// radius test into a queue and are summed as they are popped. A last item then
// starts four averaging divides, the gain terms, the halving steps, the norms,
// and per speed clamp a root loop and two divides in the shared divider.
// Reset is synchronous, active low; sums and config return to reset values.
// The output register holds a result while new items keep being taken.
module boid_velocity_update_core #(
  parameter int WINDOW_X       = 1024,
  parameter int WINDOW_Y       = 768,
  parameter int TURN_STEP_Q16  = 13107,
  parameter int MAX_NEIGHBOURS = 65535,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // self_pos_x, self_pos_y, self_vel_x, self_vel_y, nb_pos_x, nb_pos_y,
  // nb_vel_x, nb_vel_y
  input  logic [255:0]                   in_tdata,
  input  logic                           in_tuser,   // first
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // new_vel_x, new_vel_y
  input  logic                           cfg_we,
  input  logic [bvu_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bvu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bvu_pkg::cfg_t     cfg_r;
  bvu_pkg::item_t    f_item, q_item;
  logic              q_push, q_full, q_pop, q_valid;
  bvu_pkg::div_req_t div_req;
  bvu_pkg::div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bvu_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bvu_pkg::CFG_ALIGN_RADIUS: cfg_r.align_radius <= cfg_wdata;
        bvu_pkg::CFG_SEP_RADIUS:   cfg_r.sep_radius   <= cfg_wdata;
        bvu_pkg::CFG_ALIGN_GAIN:   cfg_r.align_gain   <= cfg_wdata[15:0];
        bvu_pkg::CFG_SEP_GAIN:     cfg_r.sep_gain     <= cfg_wdata[15:0];
        bvu_pkg::CFG_COH_GAIN:     cfg_r.coh_gain     <= cfg_wdata[15:0];
        bvu_pkg::CFG_MARGIN_SIZE:  cfg_r.margin_size  <= cfg_wdata;
        bvu_pkg::CFG_SPEED_LO:     cfg_r.speed_lo     <= cfg_wdata;
        bvu_pkg::CFG_SPEED_HI:     cfg_r.speed_hi     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bvu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_push    (q_push),
    .q_item    (f_item),
    .q_full    (q_full)
  );

  bvu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_item),
    .valid (q_valid)
  );

  bvu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bvu_back #(
    .WINDOW_X       (WINDOW_X),
    .WINDOW_Y       (WINDOW_Y),
    .TURN_STEP_Q16  (TURN_STEP_Q16),
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");

  a_reset_no_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result valid right after reset");

endmodule

>>> sim/tb.sv
// Self-checking bench for boid_velocity_update_core: neighbor lists in, new velocities out.
// Needs bvu_pkg and the core RTL. A built-in flocking predictor computes the expected
// velocity of all untyped items; directed rows, an extreme-config run, then random-list phases.
module tb;

  localparam longint WIN_X   = 1024;
  localparam longint WIN_Y   = 768;
  localparam longint TURN    = 13107;
  localparam longint NB_MAX  = 65535;
  localparam longint L48     = longint'(1) << 47;
  localparam longint L31     = longint'(1) << 31;
  localparam int     SETTLE  = 1200;

  typedef struct {
    logic signed [31:0] spx, spy, svx, svy, npx, npy, nvx, nvy;
    logic first, last;
  } nb_item_t;

  typedef struct {
    nb_item_t it;
    bit       typed;
    logic [63:0] vel;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser, in_tlast;
  logic [255:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [63:0] out_tdata;
  logic cfg_we;
  logic [bvu_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [bvu_pkg::CFG_DATA_W-1:0] cfg_wdata;

  boid_velocity_update_core uut (.*);

  // predictor state
  longint r_align, r_sep, g_align, g_sep, g_coh, margin, v_min, v_max;
  longint acc_px, acc_py, acc_vx, acc_vy, push_x, push_y, near_n;

  logic [63:0] vel_q[$];
  int mismatches;
  bit calm;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint sat(longint v, longint lim);
    if (v >= lim) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit within_radius(longint dx, longint dy, longint r);
    longint ax, ay;
    ax = mag(dx);
    ay = mag(dy);
    if (ax >= r || ay >= r) return 0;
    return ax * ax + ay * ay < r * r;
  endfunction

  function automatic longint gmul(longint a, longint g);
    return (a * g) >>> 16;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned speed_sq(longint x, longint y);
    return longint'(x * x) + longint'(y * y);
  endfunction

  task automatic scale_to(inout longint x, inout longint y, input longint unsigned n2,
                          input longint target);
    longint nrm, qx, qy;
    nrm = longint'(root64(n2));
    qx = mag(x) * target / nrm;
    qy = mag(y) * target / nrm;
    x = sat(x < 0 ? -qx : qx, L31);
    y = sat(y < 0 ? -qy : qy, L31);
  endtask

  task automatic clear_flock();
    acc_px = 0; acc_py = 0; acc_vx = 0; acc_vy = 0;
    push_x = 0; push_y = 0; near_n = 0;
  endtask

  // returns 1 when the item closes a list; vel = {new_vel_y, new_vel_x}
  task automatic steer(input nb_item_t it, output bit got, output logic [63:0] vel);
    longint px, py, vx, vy, nx, ny, dx, dy, ox, oy, wx, wy;
    longint unsigned n2, lmax, lmin;
    bit big;
    px = it.spx; py = it.spy; vx = it.svx; vy = it.svy;
    nx = it.npx; ny = it.npy;
    dx = nx - px; dy = ny - py;
    big = 0;
    got = 0;
    vel = '0;
    if (it.first) clear_flock();
    if (within_radius(dx, dy, r_align) && near_n < NB_MAX) begin
      acc_px += nx; acc_py += ny;
      acc_vx += longint'(it.nvx); acc_vy += longint'(it.nvy);
      near_n++;
    end
    if (within_radius(dx, dy, r_sep)) begin
      push_x = sat(push_x - dx, L48);
      push_y = sat(push_y - dy, L48);
    end
    if (!it.last) return;
    ox = vx + gmul(push_x, g_sep);
    oy = vy + gmul(push_y, g_sep);
    wx = WIN_X * 65536 - margin;
    wy = WIN_Y * 65536 - margin;
    if (near_n > 0) begin
      ox += gmul(acc_vx / near_n - vx, g_align);
      oy += gmul(acc_vy / near_n - vy, g_align);
      ox += gmul(acc_px / near_n - px, g_coh);
      oy += gmul(acc_py / near_n - py, g_coh);
    end
    if (px < margin) ox += TURN;
    if (px > wx) ox -= TURN;
    if (py < margin) oy += TURN;
    if (py > wy) oy -= TURN;
    clear_flock();
    vx = ox; vy = oy;
    while (vx >= L31 || vx < -L31 || vy >= L31 || vy < -L31) begin
      vx = vx >>> 1;
      vy = vy >>> 1;
      big = 1;
    end
    lmax = v_max * v_max;
    lmin = v_min * v_min;
    n2 = speed_sq(vx, vy);
    if (n2 != 0 && (big || n2 > lmax)) scale_to(vx, vy, n2, v_max);
    vx = sat(vx, L31);
    vy = sat(vy, L31);
    n2 = speed_sq(vx, vy);
    if (n2 != 0 && n2 < lmin) scale_to(vx, vy, n2, v_min);
    got = 1;
    vel = {vy[31:0], vx[31:0]};
  endtask

  // drives one item; on acceptance of a last item queues either the typed or the predicted velocity
  task automatic offer(input nb_item_t it, input bit typed, input logic [63:0] tvel);
    bit got;
    logic [63:0] pv;
    if (!calm && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 28);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.nvy, it.nvx, it.npy, it.npx, it.svy, it.svx, it.spy, it.spx};
    in_tuser  <= it.first;
    in_tlast  <= it.last;
    do @(posedge clk); while (!in_tready);
    steer(it, got, pv);
    if (got) vel_q.push_back(typed ? tvel : pv);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (vel_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input longint ar, sr, ag, sg, cg, ms, mn, mx);
    logic [bvu_pkg::CFG_IDX_W-1:0] idx [8];
    longint v [8];
    idx = '{bvu_pkg::CFG_ALIGN_RADIUS, bvu_pkg::CFG_SEP_RADIUS, bvu_pkg::CFG_ALIGN_GAIN,
            bvu_pkg::CFG_SEP_GAIN, bvu_pkg::CFG_COH_GAIN, bvu_pkg::CFG_MARGIN_SIZE,
            bvu_pkg::CFG_SPEED_LO, bvu_pkg::CFG_SPEED_HI};
    v = '{ar, sr, ag, sg, cg, ms, mn, mx};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[i];
      cfg_wdata <= v[i][30:0];
      @(posedge clk);
      case (idx[i])
        bvu_pkg::CFG_ALIGN_RADIUS: r_align = v[i] & 32'h7fff_ffff;
        bvu_pkg::CFG_SEP_RADIUS:   r_sep   = v[i] & 32'h7fff_ffff;
        bvu_pkg::CFG_ALIGN_GAIN:   g_align = v[i] & 16'hffff;
        bvu_pkg::CFG_SEP_GAIN:     g_sep   = v[i] & 16'hffff;
        bvu_pkg::CFG_COH_GAIN:     g_coh   = v[i] & 16'hffff;
        bvu_pkg::CFG_MARGIN_SIZE:  margin  = v[i] & 32'h7fff_ffff;
        bvu_pkg::CFG_SPEED_LO:     v_min   = v[i] & 32'h7fff_ffff;
        default:                   v_max   = v[i] & 32'h7fff_ffff;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  function automatic nb_item_t mk(longint px, py, vx, vy, nx, ny, nvx, nvy,
                                  bit f, bit l);
    nb_item_t it;
    it.spx = px; it.spy = py; it.svx = vx; it.svy = vy;
    it.npx = nx; it.npy = ny; it.nvx = nvx; it.nvy = nvy;
    it.first = f; it.last = l;
    return it;
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom;
  endfunction

  // random value near c, full range now and then
  function automatic logic [31:0] near(logic [31:0] c, int unsigned span);
    if ($urandom_range(9) == 0) return $urandom;
    return c + $urandom_range(span) - span / 2;
  endfunction

  task automatic random_lists(input int n_items);
    nb_item_t it;
    logic [31:0] px, py, vx, vy;
    int len, sent;
    sent = 0;
    while (sent < n_items) begin
      calm = (sent > n_items / 3) && (sent < n_items / 2);
      len = $urandom_range(6, 1);
      px = ($urandom_range(3) == 0) ? rnd32() : $urandom_range(WIN_X * 65536);
      py = ($urandom_range(3) == 0) ? rnd32() : $urandom_range(WIN_Y * 65536);
      vx = ($urandom_range(7) == 0) ? rnd32() : near(0, 32'h0010_0000);
      vy = ($urandom_range(7) == 0) ? rnd32() : near(0, 32'h0010_0000);
      for (int k = 0; k < len; k++) begin
        it = mk(px, py, vx, vy, near(px, 32'h0100_0000), near(py, 32'h0100_0000),
                near(vx, 32'h0008_0000), near(vy, 32'h0008_0000),
                (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0),
                (k == len - 1) ? ($urandom_range(11) != 0) : ($urandom_range(19) == 0));
        offer(it, 0, '0);
        sent++;
      end
    end
    calm = 0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (vel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %h", out_tdata);
        end else begin
          logic [63:0] want;
          want = vel_q.pop_front();
          if (out_tdata[31:0] !== want[31:0] || out_tdata[63:32] !== want[63:32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("new_vel mismatch: exp x=%h y=%h got x=%h y=%h",
                       want[31:0], want[63:32], out_tdata[31:0], out_tdata[63:32]);
          end
        end
      end
      out_tready <= calm || ($urandom_range(99) >= 28);
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    longint c_x, c_y, hi, lo;
    c_x = 512 * 65536;
    c_y = 384 * 65536;
    hi  = 32'sh7fff_ffff;
    lo  = -L31;
    mismatches = 0;
    calm = 0;
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = 0; in_tlast = 0;
    cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
    r_align = 6553600; r_sep = 1310720; g_align = 3277; g_sep = 3277; g_coh = 33;
    margin = 6553600; v_min = 196608; v_max = 393216;
    clear_flock();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone boid at rest mid-window
    r.it = mk(c_x, c_y, 0, 0, 0, 0, 0, 0, 1, 1); r.typed = 1; r.vel = '0;
    rows.push_back(r);
    // top speed along x clamps to max speed
    r.it = mk(c_x, c_y, hi, 0, 0, 0, 0, 0, 1, 1); r.typed = 1;
    r.vel = {32'd0, 32'd393216};
    rows.push_back(r);
    r.typed = 0;
    // corners: walls on both sides, halving on huge velocities
    r.it = mk(hi, hi, 0, 0, 0, 0, 0, 0, 1, 1); rows.push_back(r);
    r.it = mk(lo, lo, lo, lo, 0, 0, 0, 0, 1, 1); rows.push_back(r);
    r.it = mk(lo, hi, hi, lo, hi, lo, hi, lo, 1, 1); rows.push_back(r);
    // short list: neighbor on top, one unit off, far away
    r.it = mk(c_x, c_y, 65536, 0, c_x, c_y, 0, 65536, 1, 0); rows.push_back(r);
    r.it = mk(c_x, c_y, 65536, 0, c_x + 65536, c_y - 65536, hi, lo, 0, 0);
    rows.push_back(r);
    r.it = mk(c_x, c_y, 65536, 0, c_x + 2000000, c_y, lo, hi, 0, 1); rows.push_back(r);
    // no first mark: sums carry on from the previous item
    r.it = mk(c_x, c_y, 0, 0, c_x - 30000, c_y + 30000, 70000, -70000, 0, 0);
    rows.push_back(r);
    r.it = mk(c_x, c_y, 0, 0, c_x + 10000, c_y, 70000, 70000, 0, 1); rows.push_back(r);
    // last clears sums even without a following first
    r.it = mk(c_x, c_y, 100, -100, c_x + 5, c_y + 5, 0, 0, 0, 1); rows.push_back(r);
    // tiny nonzero speed pushed up to min speed
    r.it = mk(c_x, c_y, 1, 0, 0, 0, 0, 0, 1, 1); rows.push_back(r);
    // just at the radius edge, inside and outside
    r.it = mk(c_x, c_y, 0, 65536, c_x + 6553599, c_y, 0, 0, 1, 0); rows.push_back(r);
    r.it = mk(c_x, c_y, 0, 65536, c_x + 6553600, c_y, 0, 0, 0, 1); rows.push_back(r);
    foreach (rows[i]) offer(rows[i].it, rows[i].typed, rows[i].vel);
    settle();

    // extreme radii and gains: every neighbor counted and pushed
    write_regs(hi, hi, 65535, 65535, 65535, 0, 0, hi);
    for (int k = 0; k < 30; k++)
      offer(mk(hi, 0, 0, 0, 1, 0, $urandom, $urandom, k == 0, k == 29), 0, '0);
    settle();

    write_regs(0, 0, 0, 0, 0, 0, 0, 0);
    random_lists(80);
    settle();
    write_regs(hi, hi, 65535, 65535, 65535, hi, hi, hi);
    random_lists(80);
    settle();
    write_regs($urandom & hi, $urandom & hi, $urandom_range(65535), $urandom_range(65535),
               $urandom_range(65535), $urandom & hi, 400000, 100000);
    random_lists(80);
    settle();
    write_regs($urandom_range(32'h0200_0000), $urandom_range(32'h0080_0000),
               $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
               $urandom_range(32'h0400_0000), $urandom_range(200000),
               $urandom_range(800000, 200000));
    random_lists(110);
    settle();
    write_regs(6553600, 1310720, 3277, 3277, 33, 6553600, 196608, 393216);
    random_lists(110);
    settle();

    if (mismatches == 0 && vel_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/bvu_pkg.sv
hdl/bvu_div.sv
hdl/bvu_fifo.sv
hdl/bvu_front.sv
hdl/bvu_back.sv
hdl/boid_velocity_update_core.sv
sim/tb.sv
